### hw/rtl/prt_pkg.sv
// Package for the port rights table: request and status codes and the
// structs for the command broadcast to the cells and their flags. No dependencies.
`default_nettype none
package prt_pkg;
  localparam int unsigned PortW = 32;
  localparam int unsigned TaskW = 31;

  typedef enum logic [2:0] {
    REQ_REGISTER = 3'd0,
    REQ_CHECK_EXCL = 3'd1,
    REQ_CAN_SEND = 3'd2,
    REQ_CAN_RECV = 3'd3,
    REQ_TRANSFER = 3'd4,
    REQ_VERIFY = 3'd5,
    REQ_RSVD6 = 3'd6,
    REQ_RSVD7 = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_DENIED = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic             look;   // evaluate match flags
    logic             wr;     // apply a write
    logic [PortW-1:0] port;
    logic [TaskW-1:0] task_a; // source or owner
    logic [TaskW-1:0] task_b; // destination
    logic             right;
  } cell_cmd_t;

  // Per-cell status flags, registered in each cell and gathered across the row by the top.
  typedef struct packed {
    logic match_a;  // entry (port, task_a) exists
    logic rights_send;
    logic rights_recv;
    logic match_b;  // entry (port, task_b) exists
    logic other_rx; // receiver other than task_a/task_b
  } cell_flag_t;
endpackage
`default_nettype wire

### hw/rtl/port_rights_table_top.sv
// Port rights table: a request first latches match flags in the cell row
// (S_LOOK) and then decides and writes (S_DEC); the result word is registered
// at the end of the decide state.
// A new request is taken only in the idle state after the decide state, and
// only once the previous result leaves, so requests never overlap.
// Reset clears all valid bits and the started flag at once; no sweep.
`default_nettype none
module port_rights_table_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic [31:0] port_id_i,
  input  logic [30:0] task_id_i,
  input  logic [30:0] other_task_id_i,
  input  logic        right_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        answer_o
);
  import prt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_DEC  = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic       started_q;
  req_e       req_q;
  logic [PortW-1:0] port_q;
  logic [TaskW-1:0] task_a_q, task_b_q;
  logic       right_q;
  cell_cmd_t  cmd;
  logic [CAPACITY:0] free_chain;
  cell_flag_t flags [CAPACITY];
  logic [CAPACITY-1:0] ma, ms, mr, mb, orx, rxp;
  logic any_a, a_send, a_recv, any_b, any_orx, multi_rx;
  logic set_src, wr_b, ins_b;
  logic [1:0] st;
  logic ans;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_o || out_ready_i);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_e'(req_type_i);
      port_q <= port_id_i;
      task_a_q <= task_id_i;
      task_b_q <= (req_type_i == REQ_TRANSFER) ? other_task_id_i : task_id_i;
      right_q <= right_type_i;
    end
  end

  assign cmd = '{look: (state_q == S_LOOK), wr: (state_q == S_DEC), port: port_q,
                 task_a: task_a_q, task_b: task_b_q, right: right_q};

  assign free_chain[0] = 1'b0;
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    prt_cell u_cell (
      .clk_i, .rst_ni, .cmd_i(cmd), .free_in_i(free_chain[g]),
      .set_src_i(set_src), .wr_b_i(wr_b), .ins_b_i(ins_b),
      .free_out_o(free_chain[g+1]), .flag_o(flags[g])
    );
    assign ma[g] = flags[g].match_a;
    assign ms[g] = flags[g].rights_send;
    assign mr[g] = flags[g].rights_recv;
    assign mb[g] = flags[g].match_b;
    assign orx[g] = flags[g].other_rx;
    // For verify task_a == task_b, so receivers are the owner's plus others.
    assign rxp[g] = flags[g].other_rx || flags[g].rights_recv;
  end

  assign any_a = |ma;
  assign a_send = |ms;
  assign a_recv = |mr;
  assign any_b = |mb;
  assign any_orx = |orx;
  assign multi_rx = (rxp & (rxp - 1'b1)) != '0;

  always_comb begin
    st = ST_OK;
    ans = 1'b0;
    set_src = 1'b0;
    wr_b = 1'b0;
    ins_b = 1'b0;
    case (req_q)
      REQ_REGISTER: begin
        wr_b = 1'b1;
        ins_b = !any_b;
        if (!any_b && free_chain[CAPACITY] == 1'b0) st = ST_FULL;
      end
      REQ_CHECK_EXCL: begin
        if (!started_q) st = ST_NOT_FOUND;
        else if (right_q && any_orx) st = ST_DENIED;
      end
      REQ_CAN_SEND: ans = started_q && a_send;
      REQ_CAN_RECV: ans = started_q && a_recv;
      REQ_TRANSFER: begin
        if (!started_q) st = ST_NOT_FOUND;
        else if (right_q && any_orx) st = ST_DENIED;
        else if (!any_a) st = ST_NOT_FOUND;
        else if (right_q ? !a_recv : !a_send) st = ST_DENIED;
        else begin
          set_src = right_q;
          wr_b = 1'b1;
          ins_b = !any_b;
          if (!any_b && free_chain[CAPACITY] == 1'b0) st = ST_FULL;
        end
      end
      REQ_VERIFY: ans = !started_q || !multi_rx;
      default: ;
    endcase
  end

  always_comb begin
    case (state_q)
      S_IDLE:  state_d = (in_valid_i && in_ready_o) ? S_LOOK : S_IDLE;
      S_LOOK:  state_d = S_DEC;
      S_DEC:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      started_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DEC) begin
        out_valid_o <= 1'b1;
        if (req_q == REQ_REGISTER) started_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DEC) begin
      status_o <= st;
      answer_o <= ans;
    end
  end

`ifndef SYNTH
  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_result_after_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DEC |=> out_valid_o) else $error("result lost");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o) else $error("accept while busy");
`endif
endmodule
`default_nettype wire

### hw/rtl/prt_cell.sv
// One table slot. Holds an entry and registers its match flags.
// Depends on prt_pkg.
`default_nettype none
module prt_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prt_pkg::cell_cmd_t cmd_i,
  input  logic              free_in_i,   // some lower cell is free
  input  logic              set_src_i,   // clear receive of task_a entry
  input  logic              wr_b_i,      // OR right into task_b entry
  input  logic              ins_b_i,     // insert task_b entry if first free
  output logic              free_out_o,
  output prt_pkg::cell_flag_t flag_o
);
  import prt_pkg::*;

  logic             valid_q;
  logic [PortW-1:0] port_q;
  logic [TaskW-1:0] owner_q;
  logic [1:0]       rights_q, rights_d;
  logic             port_hit, hit_a, hit_b, take;
  cell_flag_t       flag_d, flag_q;

  assign port_hit = valid_q && (port_q == cmd_i.port);
  assign hit_a = port_hit && (owner_q == cmd_i.task_a);
  assign hit_b = port_hit && (owner_q == cmd_i.task_b);
  assign free_out_o = free_in_i || !valid_q;
  assign take = cmd_i.wr && ins_b_i && !valid_q && !free_in_i;

  always_comb begin
    flag_d.match_a = hit_a;
    flag_d.rights_send = hit_a && rights_q[0];
    flag_d.rights_recv = hit_a && rights_q[1];
    flag_d.match_b = hit_b;
    flag_d.other_rx = port_hit && !hit_a && !hit_b && rights_q[1];
  end

  // A transfer to the same task clears and then sets receive on one entry.
  always_comb begin
    rights_d = rights_q;
    if (set_src_i && hit_a) rights_d[1] = 1'b0;
    if (wr_b_i && hit_b) rights_d = rights_d | (cmd_i.right ? 2'b10 : 2'b01);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flag_q <= '0;
    end else begin
      if (cmd_i.look) flag_q <= flag_d;
      if (take) valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      if (take) begin
        port_q <= cmd_i.port;
        owner_q <= cmd_i.task_b;
        rights_q <= cmd_i.right ? 2'b10 : 2'b01;
      end else begin
        rights_q <= rights_d;
      end
    end
  end

  assign flag_o = flag_q;
endmodule
`default_nettype wire
